// ===== rtl/deoq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the drop-oldest event queue.
package deoq_pkg;

  localparam int CAT_W  = 8;
  localparam int WORD_W = 32;
  localparam int DROP_W = 16;

  // Record layout, lowest bits first: category, detail, extra.
  localparam int REC_W = CAT_W + 2 * WORD_W;

  localparam logic [CAT_W-1:0] REPORT_CATEGORY = CAT_W'(5);

  // Bit positions in the result tuser.
  localparam int USER_HAS_EVENT = 0;
  localparam int USER_IS_REPORT = 1;
  localparam int USER_W         = 2;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_REPORT,
    KIND_RECORD
  } kind_e;

  // What an accepted pop resolved to, handed from the control to the result stage.
  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [DROP_W-1:0] drop_cnt;
  } pop_t;

endpackage

// ===== rtl/deoq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module deoq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/deoq_ctrl.sv =====
`timescale 1ns / 1ps
// Queue bookkeeping: read pointer, fill count, dropped counter and RAM addressing.
module deoq_ctrl #(
  parameter  int QUEUE_DEPTH = 8,
  localparam int PTR_W       = $clog2(QUEUE_DEPTH),
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             pop_i,
  output logic             wr_en_o,
  output logic [PTR_W-1:0] wr_addr_o,
  output logic             rd_en_o,
  output logic [PTR_W-1:0] rd_addr_o,
  output deoq_pkg::pop_t   pop_o
);

  localparam int SUM_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic [deoq_pkg::DROP_W-1:0] drop_q, drop_d;

  logic             full;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail_ptr;

  assign full       = (fill_q == FULL_CNT);
  assign rd_ptr_inc = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
  assign tail_sum   = SUM_W'(rd_ptr_q) + SUM_W'(fill_q);
  // The sum stays below twice the depth, so one subtract wraps it.
  assign tail_ptr   = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);

  always_comb begin
    rd_ptr_d       = rd_ptr_q;
    fill_d         = fill_q;
    drop_d         = drop_q;
    wr_en_o        = 1'b0;
    wr_addr_o      = tail_ptr;
    rd_en_o        = 1'b0;
    rd_addr_o      = rd_ptr_q;
    pop_o.valid    = pop_i;
    pop_o.kind     = deoq_pkg::KIND_EMPTY;
    pop_o.drop_cnt = drop_q;
    if (push_i) begin
      wr_en_o = 1'b1;
      if (full) begin
        // Overwrite the oldest record and count it as dropped.
        wr_addr_o = rd_ptr_q;
        rd_ptr_d  = rd_ptr_inc;
        if (drop_q != '1) begin
          drop_d = drop_q + 1'b1;
        end
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end else if (pop_i) begin
      if (drop_q != '0) begin
        pop_o.kind = deoq_pkg::KIND_REPORT;
        drop_d     = '0;
      end else if (fill_q != '0) begin
        pop_o.kind = deoq_pkg::KIND_RECORD;
        rd_en_o    = 1'b1;
        rd_ptr_d   = rd_ptr_inc;
        fill_d     = fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      fill_q   <= '0;
      drop_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count exceeds queue depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q <= LAST_PTR)
    else $error("read pointer out of range");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q != '0 |-> full)
    else $error("drops pending while queue is not full");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push_i && drop_q != '0 |=> drop_q == '0 && $stable(fill_q))
    else $error("report did not clear drops or consumed a record");

endmodule

// ===== rtl/deoq_out.sv =====
`timescale 1ns / 1ps
// Result stage: waits for RAM read data, builds the result beat and holds it for the sink.
module deoq_out #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deoq_pkg::pop_t                    pop_i,
  input  logic [deoq_pkg::REC_W-1:0]        rd_data_i,
  output logic                              s1_free_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [deoq_pkg::USER_W-1:0]       m_axis_tuser,
  output logic [deoq_pkg::REC_W-1:0]        m_axis_tdata
);

  localparam logic [deoq_pkg::WORD_W-1:0] DEPTH_WORD = deoq_pkg::WORD_W'(QUEUE_DEPTH);

  logic                              s1_valid_q, s1_valid_d;
  deoq_pkg::kind_e                   s1_kind_q;
  logic [deoq_pkg::DROP_W-1:0]       s1_cnt_q;
  logic                              out_valid_q, out_valid_d;
  logic [deoq_pkg::USER_W-1:0]       out_user_q, out_user_d;
  logic [deoq_pkg::REC_W-1:0]        out_data_q, out_data_d;
  logic                              advance;

  // The RAM read lands during the cycle this stage holds the pop.
  assign advance   = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s1_free_o = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d = pop_i.valid ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
    out_user_d  = '0;
    out_data_d  = '0;
    case (s1_kind_q)
      deoq_pkg::KIND_REPORT: begin
        out_user_d[deoq_pkg::USER_HAS_EVENT] = 1'b1;
        out_user_d[deoq_pkg::USER_IS_REPORT] = 1'b1;
        out_data_d = {DEPTH_WORD, deoq_pkg::WORD_W'(s1_cnt_q), deoq_pkg::REPORT_CATEGORY};
      end
      deoq_pkg::KIND_RECORD: begin
        out_user_d[deoq_pkg::USER_HAS_EVENT] = 1'b1;
        out_data_d = rd_data_i;
      end
      default: begin
        out_user_d = '0;
        out_data_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i.valid) begin
      s1_kind_q <= pop_i.kind;
      s1_cnt_q  <= pop_i.drop_cnt;
    end
    if (advance) begin
      out_user_q <= out_user_d;
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/drop_oldest_event_queue.sv =====
`timescale 1ns / 1ps
// Drop-oldest event queue: a ring of event records that overwrites the oldest when full.
// Throughput: one beat (push or pop) per cycle; a result held by the sink stalls input after one more pop.
// Result path: when a pop is accepted, the RAM read and the pop's kind register together; the
// result register loads from them once the sink is not holding an earlier result beat.
// Reset clears the read pointer, fill count, dropped counter and valid flags at once;
// record storage is not cleared and is only read after being written.
module drop_oldest_event_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic                        s_axis_tuser,  // op (0 push, 1 pop)
  input  logic [deoq_pkg::REC_W-1:0]  s_axis_tdata,  // in_category, in_detail, in_extra
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [deoq_pkg::USER_W-1:0] m_axis_tuser,  // has_event, is_overflow_report
  output logic [deoq_pkg::REC_W-1:0]  m_axis_tdata   // out_category, out_detail, out_extra
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic                       s1_free;
  logic                       push;
  logic                       pop;
  logic                       wr_en;
  logic [PTR_W-1:0]           wr_addr;
  logic                       rd_en;
  logic [PTR_W-1:0]           rd_addr;
  logic [deoq_pkg::REC_W-1:0] rd_data;
  deoq_pkg::pop_t             pop_info;

  assign s_axis_tready = s1_free;
  assign push = s_axis_tvalid && s1_free && !s_axis_tuser;
  assign pop  = s_axis_tvalid && s1_free && s_axis_tuser;

  deoq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .pop_o    (pop_info)
  );

  deoq_ram #(
    .WIDTH(deoq_pkg::REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(s_axis_tdata),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  deoq_out #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_i        (pop_info),
    .rd_data_i    (rd_data),
    .s1_free_o    (s1_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
